// ===== rtl/core/abs_pkg.sv =====
// ----------------------------------------------------------------------------
// Alternating-bit sender package
// Shared types and constants for the alternating-bit sender.
// ----------------------------------------------------------------------------
package abs_pkg;

  localparam int unsigned MAX_SEGMENT = 1024;
  localparam int unsigned TIMER_WIDTH = 24;
  localparam int unsigned LEN_WIDTH   = 11;
  localparam int unsigned ACKN_WIDTH  = 32;

  localparam logic [TIMER_WIDTH-1:0] TIMEOUT_RESET = TIMER_WIDTH'(1000);
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX     = {TIMER_WIDTH{1'b1}};
  localparam logic [LEN_WIDTH-1:0]   SEG_MAX       = LEN_WIDTH'(MAX_SEGMENT);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_OPEN   = 2'd1,
    OP_SEND   = 2'd2,
    OP_HEADER = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'b0001,
    PH_SYN_WAIT  = 4'b0010,
    PH_CONNECTED = 4'b0100,
    PH_ACK_WAIT  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_CONNECTED = 3'd1,
    EV_CONFIRMED = 3'd2,
    EV_TIMEOUT   = 3'd3,
    EV_REJECTED  = 3'd4,
    EV_REFUSED   = 3'd5
  } event_t;

endpackage

// ===== rtl/core/alternating_bit_sender.sv =====
// ----------------------------------------------------------------------------
// Alternating-bit sender
// Sender side of a stop-and-wait transfer: opens with SYN, sends segments
// with an alternating sequence bit and retransmits on timeout.
// ----------------------------------------------------------------------------
// The block takes one event beat per clock and returns exactly one result beat
// for it in the cycle after acceptance. The event is decoded and the connection
// state updated in the accepting cycle; the result sits in a single output
// register, and a new event is accepted whenever that register is empty or is
// being emptied in the same cycle, so the sustained rate is one beat per clock.
// The timeout register may be written only while no event is in flight.
module alternating_bit_sender (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [abs_pkg::TIMER_WIDTH-1:0]    cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  abs_pkg::opcode_t                   in_opcode,
  input  logic [abs_pkg::LEN_WIDTH-1:0]      in_seg_length,
  input  logic                               in_seg_is_last,
  input  logic                               in_rx_checksum_ok,
  input  logic                               in_rx_syn,
  input  logic                               in_rx_ack,
  input  logic                               in_rx_fin,
  input  logic [abs_pkg::ACKN_WIDTH-1:0]     in_rx_ack_number,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_tx_valid,
  output logic                               out_tx_syn,
  output logic                               out_tx_ack,
  output logic                               out_tx_fin,
  output logic                               out_tx_sequence,
  output logic [abs_pkg::LEN_WIDTH-1:0]      out_tx_payload_size,
  output abs_pkg::event_t                    out_event_code,
  output logic                               out_ready_for_segment
);
  import abs_pkg::*;

  logic [TIMER_WIDTH-1:0] timeout_r;
  phase_t                 phase_r, phase_nxt;
  logic                   seq_r, seq_nxt;
  logic [TIMER_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [LEN_WIDTH-1:0]   psize_r, psize_nxt;
  logic                   plast_r, plast_nxt;

  logic                   ovalid_r;
  logic                   tx_valid_r, tx_valid_nxt;
  logic                   tx_syn_r, tx_syn_nxt;
  logic                   tx_ack_r, tx_ack_nxt;
  logic                   tx_fin_r, tx_fin_nxt;
  logic                   tx_seq_r, tx_seq_nxt;
  logic [LEN_WIDTH-1:0]   tx_size_r, tx_size_nxt;
  event_t                 ev_r, ev_nxt;
  logic                   rdy_seg_r;

  logic                   in_fire;
  logic                   len_ok;
  logic                   ack_match;

  assign in_ready  = !ovalid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign len_ok    = (in_seg_length != '0) && (in_seg_length <= SEG_MAX);
  assign ack_match = (in_rx_ack_number == {{(ACKN_WIDTH-1){1'b0}}, seq_r});
  assign cnt_inc   = (cnt_r == TIMER_MAX) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    phase_nxt    = phase_r;
    seq_nxt      = seq_r;
    cnt_nxt      = cnt_r;
    psize_nxt    = psize_r;
    plast_nxt    = plast_r;
    tx_valid_nxt = 1'b0;
    tx_syn_nxt   = 1'b0;
    tx_ack_nxt   = 1'b0;
    tx_fin_nxt   = 1'b0;
    tx_seq_nxt   = 1'b0;
    tx_size_nxt  = '0;
    ev_nxt       = EV_NONE;
    unique case (in_opcode)
      OP_TICK: begin
        if (phase_r == PH_SYN_WAIT || phase_r == PH_ACK_WAIT) begin
          cnt_nxt = cnt_inc;
          if (cnt_inc > timeout_r) begin
            cnt_nxt      = '0;
            ev_nxt       = EV_TIMEOUT;
            tx_valid_nxt = 1'b1;
            if (phase_r == PH_SYN_WAIT) begin
              tx_syn_nxt = 1'b1;
            end else begin
              tx_fin_nxt  = plast_r;
              tx_seq_nxt  = seq_r;
              tx_size_nxt = psize_r;
            end
          end
        end
      end
      OP_OPEN: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt    = PH_SYN_WAIT;
          cnt_nxt      = '0;
          tx_valid_nxt = 1'b1;
          tx_syn_nxt   = 1'b1;
        end else begin
          ev_nxt = EV_REFUSED;
        end
      end
      OP_SEND: begin
        if (phase_r == PH_CONNECTED && len_ok) begin
          psize_nxt    = in_seg_length;
          plast_nxt    = in_seg_is_last;
          phase_nxt    = PH_ACK_WAIT;
          cnt_nxt      = '0;
          tx_valid_nxt = 1'b1;
          tx_fin_nxt   = in_seg_is_last;
          tx_seq_nxt   = seq_r;
          tx_size_nxt  = in_seg_length;
        end else begin
          ev_nxt = EV_REFUSED;
        end
      end
      OP_HEADER: begin
        if (phase_r == PH_SYN_WAIT) begin
          if (in_rx_checksum_ok && in_rx_ack && in_rx_syn) begin
            phase_nxt    = PH_CONNECTED;
            seq_nxt      = 1'b0;
            cnt_nxt      = '0;
            ev_nxt       = EV_CONNECTED;
            tx_valid_nxt = 1'b1;
            tx_ack_nxt   = 1'b1;
          end else begin
            ev_nxt = EV_REJECTED;
          end
        end else if (phase_r == PH_ACK_WAIT) begin
          if (in_rx_checksum_ok && ack_match && (!in_rx_fin || in_rx_ack)) begin
            ev_nxt    = EV_CONFIRMED;
            phase_nxt = PH_CONNECTED;
            cnt_nxt   = '0;
            seq_nxt   = plast_r ? 1'b0 : !seq_r;
            psize_nxt = '0;
            plast_nxt = 1'b0;
          end else begin
            ev_nxt = EV_REJECTED;
          end
        end
      end
      default: begin
        ev_nxt = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      phase_r   <= PH_IDLE;
      seq_r     <= 1'b0;
      cnt_r     <= '0;
      psize_r   <= '0;
      plast_r   <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (in_fire) begin
        phase_r  <= phase_nxt;
        seq_r    <= seq_nxt;
        cnt_r    <= cnt_nxt;
        psize_r  <= psize_nxt;
        plast_r  <= plast_nxt;
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tx_valid_r <= tx_valid_nxt;
      tx_syn_r   <= tx_syn_nxt;
      tx_ack_r   <= tx_ack_nxt;
      tx_fin_r   <= tx_fin_nxt;
      tx_seq_r   <= tx_seq_nxt;
      tx_size_r  <= tx_size_nxt;
      ev_r       <= ev_nxt;
      rdy_seg_r  <= (phase_nxt == PH_CONNECTED);
    end
  end

  assign out_valid             = ovalid_r;
  assign out_tx_valid          = tx_valid_r;
  assign out_tx_syn            = tx_syn_r;
  assign out_tx_ack            = tx_ack_r;
  assign out_tx_fin            = tx_fin_r;
  assign out_tx_sequence       = tx_seq_r;
  assign out_tx_payload_size   = tx_size_r;
  assign out_event_code        = ev_r;
  assign out_ready_for_segment = rdy_seg_r;

  a_idle_counter_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE || phase_r == PH_CONNECTED) |-> (cnt_r == '0))
    else $error("Timeout counter is running outside a wait phase.");

  a_quiet_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !tx_valid_r) |->
      (!tx_syn_r && !tx_ack_r && !tx_fin_r && !tx_seq_r && tx_size_r == '0))
    else $error("Result beat without a header carries nonzero header fields.");

  a_send_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == OP_SEND && phase_r == PH_CONNECTED && len_ok)
      |=> (phase_r == PH_ACK_WAIT && ovalid_r && tx_valid_r))
    else $error("Accepted segment did not start an acknowledgement wait.");

  a_connected_acks: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && ev_r == EV_CONNECTED) |-> (tx_ack_r && rdy_seg_r && !tx_syn_r))
    else $error("Connection event without the closing ACK.");

  a_empty_takes_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !ovalid_r |-> in_ready)
    else $error("Input stalled while the result register is empty.");

endmodule
